>>> hw/rtl/sorted_counted_key_table_macros.svh
// Assertion macros for the sorted counted key table RTL.
// Depends on nothing; included by sckt_ctrl, the module that carries assertions.
`ifndef SORTED_COUNTED_KEY_TABLE_MACROS_SVH
`define SORTED_COUNTED_KEY_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define SCKT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define SCKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sckt_pkg.sv
// Shared types and constants of the sorted counted key table.
// Used by sckt_ctrl, sckt_datapath and sorted_counted_key_table; no dependencies.
package sckt_pkg;

  // Fixed field widths
  localparam int KEY_W    = 64;
  localparam int REQ_W    = 4;
  localparam int STATUS_W = 2;
  localparam int OCC_BITS = 8;

  // Request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_DONE      = 2'd0,
    RES_KEPT      = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_FULL      = 2'd3
  } res_t;

  // Table update applied by the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC,
    OP_DEC,
    OP_INSERT,
    OP_DELETE
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming request word
    logic search;  // register per-entry compare flags
    logic apply;   // update the table and load the result word
    op_t  op;
    res_t result;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_remove;
    logic found;
    logic last_one;  // matching entry holds a count of at most one
    logic full;
  } dp_stat_t;

endpackage

>>> hw/rtl/sckt_datapath.sv
// Datapath: a row of key/count cells with per-cell compare and shift.
// Depends on sckt_pkg; driven by sckt_ctrl through ctl_cmd_t.
module sckt_datapath #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BITS    = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_cmd,
  input  logic [sckt_pkg::KEY_W-1:0]    in_key,
  input  logic [sckt_pkg::REQ_W-1:0]    in_requester,
  input  sckt_pkg::ctl_cmd_t            cmd,
  output sckt_pkg::dp_stat_t            stat,
  output logic [sckt_pkg::STATUS_W-1:0] out_status,
  output logic [sckt_pkg::REQ_W-1:0]    out_reply_to,
  output logic [sckt_pkg::OCC_BITS-1:0] out_occupancy
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  // Request word
  logic                      req_cmd_r;
  logic [KEY_BITS-1:0]       req_key_r;
  logic [sckt_pkg::REQ_W-1:0] req_who_r;

  // Table cells and fill count
  logic [KEY_BITS-1:0]   key_r   [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   key_nxt [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_r   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_nxt [TABLE_DEPTH];
  logic [UW-1:0]         used_r;
  logic [UW-1:0]         used_nxt;

  // Compare flags
  logic [TABLE_DEPTH-1:0] ge_c, eq_c, first_c, hit_c, le1_c;
  logic [TABLE_DEPTH-1:0] ge_r, hit_r, first_a;

  // Result word
  logic [sckt_pkg::STATUS_W-1:0] status_r;
  logic [sckt_pkg::REQ_W-1:0]    reply_r;
  logic [sckt_pkg::OCC_BITS-1:0] occ_r;

  // Latch request on acceptance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r <= in_cmd;
      req_key_r <= in_key[KEY_BITS-1:0];
      req_who_r <= in_requester;
    end
  end

  // Per-cell compare and update
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [UW-1:0] IDX = UW'(i);

    logic                  below_ge;
    logic [KEY_BITS-1:0]   below_key, above_key;
    logic [COUNT_BITS-1:0] below_cnt, above_cnt;

    // entries past the fill count compare as not below the key
    assign ge_c[i]  = (IDX >= used_r) || (key_r[i] >= req_key_r);
    assign eq_c[i]  = (key_r[i] == req_key_r);
    assign le1_c[i] = (cnt_r[i] <= COUNT_BITS'(1));

    if (i == 0) begin : g_bottom
      assign first_c[i] = ge_c[i];
      assign first_a[i] = ge_r[i];
      assign below_ge   = 1'b0;
      assign below_key  = key_r[i];
      assign below_cnt  = cnt_r[i];
    end else begin : g_mid
      assign first_c[i] = ge_c[i] & ~ge_c[i-1];
      assign first_a[i] = ge_r[i] & ~ge_r[i-1];
      assign below_ge   = ge_r[i-1];
      assign below_key  = key_r[i-1];
      assign below_cnt  = cnt_r[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign above_key = key_r[i];
      assign above_cnt = cnt_r[i];
    end else begin : g_low
      assign above_key = key_r[i+1];
      assign above_cnt = cnt_r[i+1];
    end

    assign hit_c[i] = first_c[i] & eq_c[i] & (IDX < used_r);

    // next value of this cell
    always_comb begin
      key_nxt[i] = key_r[i];
      cnt_nxt[i] = cnt_r[i];
      if (cmd.apply) begin
        case (cmd.op)
          sckt_pkg::OP_INSERT: begin
            if (first_a[i]) begin
              key_nxt[i] = req_key_r;
              cnt_nxt[i] = COUNT_BITS'(1);
            end else if (below_ge) begin
              key_nxt[i] = below_key;
              cnt_nxt[i] = below_cnt;
            end
          end
          sckt_pkg::OP_DELETE: begin
            if (ge_r[i]) begin
              key_nxt[i] = above_key;
              cnt_nxt[i] = above_cnt;
            end
          end
          sckt_pkg::OP_INC: begin
            if (hit_r[i] && !(&cnt_r[i])) cnt_nxt[i] = cnt_r[i] + COUNT_BITS'(1);
          end
          sckt_pkg::OP_DEC: begin
            if (hit_r[i] && (cnt_r[i] != '0)) cnt_nxt[i] = cnt_r[i] - COUNT_BITS'(1);
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      key_r[i] <= key_nxt[i];
      cnt_r[i] <= cnt_nxt[i];
    end
  end

  // Compare flags held for the apply cycle
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      ge_r  <= ge_c;
      hit_r <= hit_c;
    end
  end

  // Status back to the controller
  assign stat.is_remove = (req_cmd_r == sckt_pkg::CMD_REMOVE);
  assign stat.found     = |hit_r;
  assign stat.last_one  = |(hit_r & le1_c);
  assign stat.full      = (used_r == UW'(TABLE_DEPTH));

  // Fill count
  always_comb begin
    used_nxt = used_r;
    if (cmd.apply) begin
      case (cmd.op)
        sckt_pkg::OP_INSERT: used_nxt = used_r + UW'(1);
        sckt_pkg::OP_DELETE: used_nxt = used_r - UW'(1);
        default:             used_nxt = used_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r <= cmd.result;
      reply_r  <= req_who_r;
      occ_r    <= sckt_pkg::OCC_BITS'(used_nxt);
    end
  end

  assign out_status    = status_r;
  assign out_reply_to  = reply_r;
  assign out_occupancy = occ_r;

endmodule

>>> hw/rtl/sckt_ctrl.sv
// Controller: sequences search and apply, decides the update and result code.
// Depends on sckt_pkg and sorted_counted_key_table_macros.svh.
`include "sorted_counted_key_table_macros.svh"

module sckt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sckt_pkg::dp_stat_t stat,
  output sckt_pkg::ctl_cmd_t cmd
);

  sckt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             apply_go;
  logic             accept;

  // Apply only when the result register is free or being emptied
  assign apply_go = (state_r == sckt_pkg::ST_APPLY) && (!out_valid_r || !out_stall);
  assign in_stall = !(rst_n && ((state_r == sckt_pkg::ST_IDLE) || apply_go));
  assign accept   = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sckt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = apply_go ? 1'b1 : (out_valid_r && out_stall);
    cmd.load      = accept;
    cmd.search    = (state_r == sckt_pkg::ST_SEARCH);
    cmd.apply     = apply_go;
    cmd.op        = sckt_pkg::OP_NONE;
    cmd.result    = sckt_pkg::RES_DONE;

    // update decision from the registered compare flags
    if (!stat.is_remove) begin
      if (stat.found) begin
        cmd.op = sckt_pkg::OP_INC;
      end else if (stat.full) begin
        cmd.result = sckt_pkg::RES_FULL;
      end else begin
        cmd.op = sckt_pkg::OP_INSERT;
      end
    end else begin
      if (!stat.found) begin
        cmd.result = sckt_pkg::RES_NOT_FOUND;
      end else if (stat.last_one) begin
        cmd.op = sckt_pkg::OP_DELETE;
      end else begin
        cmd.op     = sckt_pkg::OP_DEC;
        cmd.result = sckt_pkg::RES_KEPT;
      end
    end

    unique case (state_r)
      sckt_pkg::ST_IDLE: begin
        if (accept) state_nxt = sckt_pkg::ST_SEARCH;
      end
      sckt_pkg::ST_SEARCH: begin
        state_nxt = sckt_pkg::ST_APPLY;
      end
      sckt_pkg::ST_APPLY: begin
        if (apply_go) state_nxt = accept ? sckt_pkg::ST_SEARCH : sckt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sckt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // Checks
  `SCKT_ASSERT_NEXT(a_accept_to_search, clk, rst_n, accept, state_r == sckt_pkg::ST_SEARCH, "accepted word did not start a search")
  `SCKT_ASSERT_NEXT(a_search_to_apply, clk, rst_n, state_r == sckt_pkg::ST_SEARCH, state_r == sckt_pkg::ST_APPLY, "search not followed by apply")
  `SCKT_ASSERT_NOW(a_no_accept_in_search, clk, rst_n, state_r == sckt_pkg::ST_SEARCH, in_stall, "input taken during search")
  `SCKT_ASSERT_NEXT(a_apply_gives_result, clk, rst_n, apply_go, out_valid_r, "apply did not present a result")

endmodule

>>> hw/rtl/sorted_counted_key_table.sv
// Channel    Ports                                    Direction
// input      in_valid, in_stall, in_cmd/key/requester into block
// result     out_valid, out_stall, out_status/        out of block
//            out_reply_to/out_occupancy
//
// Each request goes through two steps: one to compare the key against every cell
// and register the position flags, one to shift or update the cells.
// out_valid is set by the apply step; the next request is taken on the apply edge,
// so a new request is accepted while the previous one is being applied.
// Synchronous active-low reset clears the controller and the fill count; cells need no clear.
// A stalled result holds the apply step, and with it the input side.
// Top level of the sorted counted key table; depends on sckt_pkg,
// sckt_ctrl and sckt_datapath.
module sorted_counted_key_table #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BITS    = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [sckt_pkg::KEY_W-1:0]    in_key,
  input  logic [sckt_pkg::REQ_W-1:0]    in_requester,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sckt_pkg::STATUS_W-1:0] out_status,
  output logic [sckt_pkg::REQ_W-1:0]    out_reply_to,
  output logic [sckt_pkg::OCC_BITS-1:0] out_occupancy
);

  sckt_pkg::ctl_cmd_t cmd;
  sckt_pkg::dp_stat_t stat;

  // Sequencer
  sckt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Cell row and result word
  sckt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_requester  (in_requester),
    .cmd           (cmd),
    .stat          (stat),
    .out_status    (out_status),
    .out_reply_to  (out_reply_to),
    .out_occupancy (out_occupancy)
  );

endmodule
